// ----- src/cspu_pkg.sv -----
// shared types, constants and helpers for the can signal pack/unpack core
`timescale 1ns / 1ps

package cspu_pkg;

    localparam int DEF_PAYLOAD_BYTES = 8;
    localparam int DATA_W            = 64;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 7;
    localparam int POS_W             = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BIT  = 2'd0,
        REG_FIELD_SIZE = 2'd1,
        REG_ORDER_MODE = 2'd2,
        REG_IS_SIGNED  = 2'd3
    } cfg_reg_t;

    localparam logic ORDER_MOTOROLA = 1'b0;
    localparam logic ORDER_INTEL    = 1'b1;

    localparam logic [5:0] RST_START_BIT  = 6'd0;
    localparam logic [6:0] RST_FIELD_SIZE = 7'd8;
    localparam logic       RST_ORDER_MODE = ORDER_MOTOROLA;
    localparam logic       RST_IS_SIGNED  = 1'b0;

    typedef struct packed {
        logic [5:0] start_bit;
        logic [6:0] field_size;
        logic       order_mode;
        logic       is_signed;
    } cfg_t;

    // motorola walk order: same byte, bit index mirrored within the byte
    function automatic logic [POS_W-1:0] saw_index(input logic [POS_W-1:0] pos);
        saw_index = {pos[POS_W-1:3], ~pos[2:0]};
    endfunction

endpackage

// ----- src/cspu_cfg_regs.sv -----
// configuration register bank of the can signal pack/unpack core
`timescale 1ns / 1ps

module cspu_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cspu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cspu_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cspu_pkg::cfg_t                    cfg
);

    cspu_pkg::cfg_t cfg_reg;
    cspu_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cspu_pkg::cfg_reg_t'(cfg_index))
                cspu_pkg::REG_START_BIT:  cfg_next.start_bit  = cfg_data[5:0];
                cspu_pkg::REG_FIELD_SIZE: cfg_next.field_size = cfg_data[6:0];
                cspu_pkg::REG_ORDER_MODE: cfg_next.order_mode = cfg_data[0];
                cspu_pkg::REG_IS_SIGNED:  cfg_next.is_signed  = cfg_data[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_bit  <= cspu_pkg::RST_START_BIT;
            cfg_reg.field_size <= cspu_pkg::RST_FIELD_SIZE;
            cfg_reg.order_mode <= cspu_pkg::RST_ORDER_MODE;
            cfg_reg.is_signed  <= cspu_pkg::RST_IS_SIGNED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/cspu_field_map.sv -----
// bit-position mapping: field extraction, insertion and range check
`timescale 1ns / 1ps

module cspu_field_map
#(
    parameter int PAYLOAD_BYTES = cspu_pkg::DEF_PAYLOAD_BYTES
)
(
    input  cspu_pkg::cfg_t                  cfg,
    input  logic [cspu_pkg::DATA_W-1:0]     payload_in,
    input  logic [cspu_pkg::DATA_W-1:0]     raw_value,
    output logic [cspu_pkg::DATA_W-1:0]     extracted_value,
    output logic [cspu_pkg::DATA_W-1:0]     payload_out,
    output logic                            range_error
);

    localparam int PW  = cspu_pkg::POS_W;
    localparam int LIM = (PAYLOAD_BYTES >= 8) ? 64 : PAYLOAD_BYTES * 8;
    localparam logic [PW:0] LIM_V = (PW+1)'(LIM);

    logic            intel;
    logic [PW-1:0]   n;
    logic [PW-1:0]   nm1;
    logic [PW-1:0]   base;
    logic [PW:0]     end_pos;
    logic [cspu_pkg::DATA_W-1:0] ext_raw;

    always_comb
    begin
        intel   = (cfg.order_mode == cspu_pkg::ORDER_INTEL);
        n       = (cfg.field_size > PW'(64)) ? PW'(64) : cfg.field_size;
        nm1     = n - PW'(1);
        base    = intel ? {1'b0, cfg.start_bit}
                        : cspu_pkg::saw_index({1'b0, cfg.start_bit});
        // walk index one past the last field bit
        end_pos = {1'b0, base} + {1'b0, n};
        range_error = (n != '0) && (end_pos > LIM_V);
    end

    // extraction: each value bit picks its payload position
    always_comb
    begin
        logic [PW-1:0] k;
        logic [PW-1:0] t;
        logic [PW-1:0] p;
        ext_raw = '0;
        for (int d = 0; d < cspu_pkg::DATA_W; d++)
        begin
            k = intel ? PW'(d) : (nm1 - PW'(d));
            t = base + k;
            p = intel ? t : cspu_pkg::saw_index(t);
            if ((PW'(d) < n) && ({1'b0, t} < LIM_V))
                ext_raw[d] = payload_in[p[5:0]];
        end
    end

    // sign extension above the field msb
    always_comb
    begin
        extracted_value = ext_raw;
        if (cfg.is_signed && (n != '0) && (n < PW'(64)) && ext_raw[nm1[5:0]])
            extracted_value = ext_raw | ({cspu_pkg::DATA_W{1'b1}} << n);
    end

    // insertion: each payload position picks its value bit
    always_comb
    begin
        logic [PW-1:0] q;
        logic [PW-1:0] k;
        logic [PW-1:0] d;
        payload_out = payload_in;
        for (int p = 0; p < LIM; p++)
        begin
            q = intel ? PW'(p) : cspu_pkg::saw_index(PW'(p));
            k = q - base;
            d = intel ? k : (nm1 - k);
            if ((q >= base) && (k < n))
                payload_out[p] = raw_value[d[5:0]];
        end
    end

endmodule

// ----- src/can_signal_pack_unpack_core.sv -----
// top level of the can signal pack/unpack core
`timescale 1ns / 1ps

// Extracts a DBC signal field from a 64-bit CAN payload and writes a raw
// value into the same field, in Intel or Motorola bit order, with optional
// sign extension of the extracted value. One item is accepted per clock
// when the output side keeps up; each item is held first in the input
// register and then in the result register, with the bit mapping done by
// combinational muxing between them. Configuration is written through
// cfg_we/cfg_index/cfg_data and must only change while no item is in
// flight. range_error flags a field that runs past the payload; bits that
// fall outside are read as zero and not written.
module can_signal_pack_unpack_core
#(
    parameter int PAYLOAD_BYTES = cspu_pkg::DEF_PAYLOAD_BYTES
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cspu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cspu_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cspu_pkg::DATA_W-1:0]       payload_in,
    input  logic [cspu_pkg::DATA_W-1:0]       raw_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cspu_pkg::DATA_W-1:0]       extracted_value,
    output logic [cspu_pkg::DATA_W-1:0]       payload_out,
    output logic                              range_error
);

    cspu_pkg::cfg_t cfg;

    logic                          s1_valid_reg;
    logic [cspu_pkg::DATA_W-1:0]   s1_payload_reg;
    logic [cspu_pkg::DATA_W-1:0]   s1_raw_reg;
    logic                          out_valid_reg;
    logic [cspu_pkg::DATA_W-1:0]   ext_reg;
    logic [cspu_pkg::DATA_W-1:0]   pout_reg;
    logic                          err_reg;

    logic [cspu_pkg::DATA_W-1:0]   ext_next;
    logic [cspu_pkg::DATA_W-1:0]   pout_next;
    logic                          err_next;
    logic                          out_en;
    logic                          in_take;

    cspu_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cspu_field_map #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_map
    (
        .cfg             (cfg),
        .payload_in      (s1_payload_reg),
        .raw_value       (s1_raw_reg),
        .extracted_value (ext_next),
        .payload_out     (pout_next),
        .range_error     (err_next)
    );

    // result register loads whenever it is empty or being drained
    assign out_en   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_en;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || out_en)
                s1_valid_reg <= in_valid;
            if (out_en)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_payload_reg <= payload_in;
            s1_raw_reg     <= raw_value;
        end
        if (out_en && s1_valid_reg)
        begin
            ext_reg  <= ext_next;
            pout_reg <= pout_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign extracted_value = ext_reg;
    assign payload_out     = pout_reg;
    assign range_error     = err_reg;

`ifndef SYNTHESIS
    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("input taken while both stages full and output stalled");

    a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted item not held in input register");

    a_s1_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_stall) |=> out_valid_reg)
        else $error("item in input register did not reach result register");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !s1_valid_reg) |=> !out_valid_reg)
        else $error("result repeated after it was taken");
`endif

endmodule
